// ===== sv/ghsc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ghsc_pkg
// Shared types, constants, exponential table and colour ramp functions.
// ---------------------------------------------------------------------------
package ghsc_pkg;

    localparam int MAX_WIDTH       = 256;
    localparam int MAX_HEIGHT      = 256;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int EXW = $clog2(EXP_TABLE_DEPTH);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_SCALE  = 3'd2,
        CFG_SIGMA  = 3'd3,
        CFG_INV    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WSETUP,
        ST_WIN,
        ST_PIX_D,
        ST_PIX_E,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_RD_WAIT,
        ST_RD_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Table entry k is exp(-16k/DEPTH) in Q1.16, from a Taylor series in Q30
    // followed by five squarings.
    function automatic logic [16:0] exp_entry(input int k);
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] term;
        y    = (64'(k) << 29) / 64'(EXP_TABLE_DEPTH);
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            if ((n % 2) == 1) sum = sum - term;
            else sum = sum + term;
        end
        for (int s = 0; s < 5; s++) begin
            sum = (sum * sum + (64'd1 << 29)) >> 30;
        end
        sum = (sum + (64'd1 << 13)) >> 14;
        return sum[16:0];
    endfunction

    // Blue/green/red ramp of one level.
    function automatic logic [23:0] ramp(input logic [7:0] v);
        logic [15:0] bl;
        logic [7:0]  up;
        logic [8:0]  rd;
        logic [8:0]  gap;
        logic [9:0]  gr;
        bl = 16'd0;
        rd = 9'd0;
        up = v - 8'd128;
        if (v < 8'd128) bl = (16'd255 * (16'd128 - 16'(v))) >> 7;
        // 255*t/127 is 2t, plus one only when t reaches 127.
        if (v > 8'd128) rd = {up, 1'b0} + ((up == 8'd127) ? 9'd1 : 9'd0);
        gap = (v >= 8'd128) ? 9'(v) - 9'd128 : 9'd128 - 9'(v);
        gr = ({gap, 1'b0} >= 10'd255) ? 10'd0 : 10'd255 - {gap, 1'b0};
        return {bl[7:0], gr[7:0], rd[7:0]};
    endfunction

endpackage

// ===== sv/gaussian_heatmap_splat_colormap.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_heatmap_splat_colormap
// Gaussian splat accumulator image with normalized colormap readout.
// ---------------------------------------------------------------------------
// One item is taken at a time and gives one result beat. A clear writes
// every cell of the 65536-cell store; the same sweep runs once after reset,
// and no item is accepted until it finishes. An add point sets up its
// window, checks each row of the clipped window, and passes each pixel
// through distance, exponent and table read, weight select and write-back.
// A read pixel reads its cell and then runs the one-bit-per-cycle divider,
// which it skips when the pixel lies outside the image or the image is
// empty. A result beat that waits in the output register holds off the
// next item until the cycle in which it is taken.
module gaussian_heatmap_splat_colormap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  level,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red
);
    import ghsc_pkg::*;

    logic [8:0]  width_reg, height_reg;
    logic [15:0] scale_reg, sigma_reg;
    logic [23:0] inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            scale_reg  <= 16'd256;
            sigma_reg  <= 16'd256;
            inv_reg    <= 24'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[8:0];
                CFG_HEIGHT: height_reg <= cfg_data[8:0];
                CFG_SCALE:  scale_reg  <= cfg_data[15:0];
                CFG_SIGMA:  sigma_reg  <= cfg_data[15:0];
                CFG_INV:    inv_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped image size, 1 .. 256.
    logic [8:0] w_eff, h_eff;
    assign w_eff = (width_reg == 9'd0) ? 9'd1 :
                   (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == 9'd0) ? 9'd1 :
                   (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;

    // Density store, one read and one write per cycle.
    logic [31:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    logic [16:0] exp_rom [EXP_TABLE_DEPTH];
    always_comb
    begin
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) exp_rom[k] = exp_entry(k);
    end

    state_t state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [31:0]   max_reg, max_next;
    logic [31:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [8:0]    minx_reg, minx_next, maxx_reg, maxx_next;
    logic [8:0]    maxy_reg, maxy_next;
    logic [8:0]    x_reg, x_next, y_reg, y_next;
    logic [36:0]   d2_reg, d2_next;
    logic          wzero_reg, wzero_next;
    logic [16:0]   wgt_reg, wgt_next;
    logic          inimg_reg, inimg_next;
    logic          empty_reg, empty_next;
    logic          ov_reg, ov_next;
    logic [7:0]    lvl_reg, lvl_next;
    logic [23:0]   rgb_reg, rgb_next;
    logic          started_reg;

    logic          div_start, div_done;
    logic [39:0]   div_q;
    logic [39:0]   num;

    assign num = 40'(mem_rdata) * 40'd255;

    ghsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num),
        .divisor  (max_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Window bounds from the scaled centres; all values fit in 34 bits.
    logic [33:0] s3;
    logic [33:0] ax_lo, ax_hi, ay_lo, ay_hi;
    logic [25:0] hx, hy;
    logic [33:0] dxs, dys;
    logic [17:0] dxa, dya;
    logic [60:0] expo;
    logic [EXW-1:0] lut_idx;
    logic [16:0] lut_q;
    logic [31:0] sum_cell;
    logic [32:0] sum_wide;
    logic [31:0] rd_clip;

    assign s3    = 34'(sigma_reg) * 34'd3;
    assign ax_lo = {2'b0, cx_reg} - s3;
    assign ay_lo = {2'b0, cy_reg} - s3;
    assign ax_hi = ({2'b0, cx_reg} + s3 + 34'd255) >> 8;
    assign ay_hi = ({2'b0, cy_reg} + s3 + 34'd255) >> 8;
    assign hx    = ax_hi[25:0];
    assign hy    = ay_hi[25:0];
    assign dxs   = {17'd0, x_reg[7:0], 8'd0} - {2'b0, cx_reg};
    assign dys   = {17'd0, y_reg[7:0], 8'd0} - {2'b0, cy_reg};
    assign dxa   = 18'(dxs[33] ? -dxs : dxs);
    assign dya   = 18'(dys[33] ? -dys : dys);
    assign expo  = 61'(d2_reg) * 61'(inv_reg);
    assign lut_idx  = expo[35:26];
    assign sum_wide = {1'b0, mem_rdata} + 33'(wgt_reg);
    assign sum_cell = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    assign rd_clip  = (div_q > 40'd255) ? 32'd255 : div_q[31:0];

    // Exponential table read with registered data.
    always_ff @(posedge clk)
    begin
        lut_q <= exp_rom[lut_idx];
    end

    logic done_clear;
    assign done_clear = (clr_reg == (AW+1)'(MAX_WIDTH*MAX_HEIGHT));

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        max_next   = max_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        minx_next  = minx_reg;
        maxx_next  = maxx_reg;
        maxy_next  = maxy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d2_next    = d2_reg;
        wzero_next = wzero_reg;
        wgt_next   = wgt_reg;
        inimg_next = inimg_reg;
        empty_next = empty_reg;
        ov_next    = ov_reg;
        lvl_next   = lvl_reg;
        rgb_next   = rgb_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg[AW-1:0];
        mem_wdata  = 32'd0;
        mem_raddr  = {y_reg[YW-1:0], x_reg[XW-1:0]};
        div_start  = 1'b0;
        in_ready   = 1'b0;

        if (ov_reg && out_ready) ov_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !ov_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    unique case (op_t'(opcode))
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            max_next   = 32'd0;
                            state_next = ST_CLEAR;
                        end
                        OP_ADD:
                        begin
                            cx_next    = 32'(point_x) * 32'(scale_reg);
                            cy_next    = 32'(point_y) * 32'(scale_reg);
                            state_next = ST_WSETUP;
                        end
                        OP_READ:
                        begin
                            x_next     = {1'b0, pixel_x};
                            y_next     = {1'b0, pixel_y};
                            inimg_next = (9'(pixel_x) < w_eff) && (9'(pixel_y) < h_eff);
                            state_next = ST_RD_WAIT;
                        end
                        default:
                        begin
                            lvl_next = 8'd0;
                            rgb_next = 24'd0;
                            ov_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (done_clear)
                begin
                    lvl_next   = 8'd0;
                    rgb_next   = 24'd0;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we   = 1'b1;
                    clr_next = clr_reg + (AW+1)'(1);
                end
            end
            ST_WSETUP:
            begin
                minx_next = (ax_lo[33] || ax_lo == 34'd0 || ax_lo[33:8] >= 26'(MAX_WIDTH))
                            ? (ax_lo[33] || ax_lo == 34'd0 ? 9'd0 : 9'h1FF)
                            : 9'(ax_lo[33:8]);
                y_next    = (ay_lo[33] || ay_lo == 34'd0) ? 9'd0 :
                            (ay_lo[33:8] >= 26'(MAX_HEIGHT)) ? 9'h1FF : 9'(ay_lo[33:8]);
                maxx_next = (hx > 26'(w_eff - 9'd1)) ? w_eff - 9'd1 : 9'(hx);
                maxy_next = (hy > 26'(h_eff - 9'd1)) ? h_eff - 9'd1 : 9'(hy);
                state_next = ST_WIN;
            end
            ST_WIN:
            begin
                x_next = minx_reg;
                if (minx_reg > maxx_reg || y_reg > maxy_reg)
                begin
                    lvl_next   = 8'd0;
                    rgb_next   = 24'd0;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
                else state_next = ST_PIX_D;
            end
            ST_PIX_D:
            begin
                d2_next    = 37'(dxa) * 37'(dxa) + 37'(dya) * 37'(dya);
                state_next = ST_PIX_E;
            end
            ST_PIX_E:
            begin
                // At or beyond exponent 16 the weight is zero.
                wzero_next = (expo[60:36] != 25'd0);
                state_next = ST_PIX_RD;
            end
            ST_PIX_RD:
            begin
                wgt_next   = wzero_reg ? 17'd0 : lut_q;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {y_reg[YW-1:0], x_reg[XW-1:0]};
                mem_wdata = sum_cell;
                if (sum_cell > max_reg) max_next = sum_cell;
                if (x_reg == maxx_reg)
                begin
                    x_next = minx_reg;
                    y_next = y_reg + 9'd1;
                    state_next = ST_WIN;
                end
                else
                begin
                    x_next = x_reg + 9'd1;
                    state_next = ST_PIX_D;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RD_MUL;
            end
            ST_RD_MUL:
            begin
                empty_next = !inimg_reg || (max_reg == 32'd0);
                if (!inimg_reg || max_reg == 32'd0)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
                div_start = inimg_reg && (max_reg != 32'd0);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    lvl_next   = rd_clip[7:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (empty_reg) lvl_next = 8'd0;
                rgb_next   = ramp(empty_reg ? 8'd0 : lvl_reg);
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Marks that the clear sweep was started by an item, not by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) started_reg <= 1'b0;
        else if (state_reg == ST_IDLE) started_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            max_reg   <= 32'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            max_reg   <= max_next;
            // The reset sweep ends without a beat.
            ov_reg    <= (state_reg == ST_CLEAR && done_clear && !started_reg)
                         ? 1'b0 : ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        minx_reg  <= minx_next;
        maxx_reg  <= maxx_next;
        maxy_reg  <= maxy_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        d2_reg    <= d2_next;
        wzero_reg <= wzero_next;
        wgt_reg   <= wgt_next;
        inimg_reg <= inimg_next;
        empty_reg <= empty_next;
        lvl_reg   <= lvl_next;
        rgb_reg   <= rgb_next;
    end

    assign out_valid = ov_reg;
    assign level     = lvl_reg;
    assign blue      = rgb_reg[23:16];
    assign green     = rgb_reg[15:8];
    assign red       = rgb_reg[7:0];
endmodule

// ===== sv/ghsc_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ghsc_divider
// Restoring divider, one quotient bit per cycle, 40-bit dividend by 32 bits.
// ---------------------------------------------------------------------------
module ghsc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [39:0] quotient
);
    logic [39:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[39]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 33'd0;
            dvs_next  = divisor;
            cnt_next  = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== sv/ghsc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ghsc_checker
// Port-level checks of the heatmap block, bound to the top level.
// ---------------------------------------------------------------------------
module ghsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] level,
    input logic [7:0] blue,
    input logic [7:0] green,
    input logic [7:0] red
);
    // A stalled result beat holds its level and blue.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(blue))
        else $error("result beat changed while stalled");

    // Blue and red are never both lit.
    a_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blue == 8'd0) || (red == 8'd0))
        else $error("blue and red both nonzero");

    // Level 128 is pure green.
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level == 8'd128 |-> green == 8'd255 && blue == 8'd0)
        else $error("midpoint color wrong");

    // A result beat that is not taken holds off the input.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted while a result beat was stalled");
endmodule

bind gaussian_heatmap_splat_colormap ghsc_checker u_ghsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .blue      (blue),
    .green     (green),
    .red       (red)
);

// ===== tb/gaussian_heatmap_splat_colormap_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_heatmap_splat_colormap_tb
// Self-checking bench for the Gaussian splat heatmap with colormap readout.
// A queue-fed driver offers clear, add-point, read-pixel and unused-opcode
// beats under random idling. A local copy of the accumulator image predicts
// each result beat, and the monitor compares it field by field. Configuration
// changes only between phases, once the block has drained.
// ---------------------------------------------------------------------------
module gaussian_heatmap_splat_colormap_tb;
    import ghsc_pkg::*;

    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;

    typedef struct {
        op_t         op;
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  rx;
        logic [7:0]  ry;
    } heat_cmd_t;

    typedef struct {
        logic [7:0] level;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } heat_px_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  level;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;

    heat_cmd_t   cmd_q[$];
    heat_px_t    pixel_q[$];
    logic [31:0] density [MAX_WIDTH*MAX_HEIGHT];
    logic [31:0] peak;
    logic [16:0] gauss_lut [EXP_TABLE_DEPTH];
    int unsigned img_w, img_h, scale, sigma, inv_sq;
    int unsigned send_idle, recv_idle;
    int unsigned fails;
    int unsigned cycles;
    int unsigned beats_seen;
    int unsigned hold_cnt;
    bit          held;

    gaussian_heatmap_splat_colormap dut (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic heat_px_t colormap(input int unsigned v);
        heat_px_t    r;
        int unsigned gap;
        r.level = v[7:0];
        r.blue  = (v < 128) ? 8'((255 * (128 - v)) / 128) : 8'd0;
        r.red   = (v > 128) ? 8'((255 * (v - 128)) / 127) : 8'd0;
        gap     = (v >= 128) ? v - 128 : 128 - v;
        r.green = (2 * gap >= 255) ? 8'd0 : 8'(255 - 2 * gap);
        return r;
    endfunction

    function automatic void splat_span(input longint c, input longint lim,
                                       output longint lo, output longint hi);
        longint a;
        longint b;
        a  = c - 3 * longint'(sigma);
        b  = c + 3 * longint'(sigma);
        lo = (a <= 0) ? 0 : (a >>> 8);
        hi = (b + 255) >>> 8;
        if (hi > lim - 1) hi = lim - 1;
    endfunction

    // Updates the local image for one beat and returns the expected result.
    function automatic heat_px_t apply_item(input heat_cmd_t c);
        heat_px_t         r;
        longint           w, h, cx, cy, x0, x1, y0, y1, dx, dy;
        longint unsigned  e, s;
        logic [31:0]      wgt;
        int               idx;
        longint unsigned  v;
        w = (img_w < 1) ? 1 : ((img_w > MAX_WIDTH) ? MAX_WIDTH : img_w);
        h = (img_h < 1) ? 1 : ((img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h);
        r = '{8'd0, 8'd0, 8'd0, 8'd0};
        case (c.op)
            OP_CLEAR:
            begin
                foreach (density[i]) density[i] = '0;
                peak = '0;
            end
            OP_ADD:
            begin
                cx = longint'(c.px) * scale;
                cy = longint'(c.py) * scale;
                splat_span(cx, w, x0, x1);
                splat_span(cy, h, y0, y1);
                for (longint y = y0; y <= y1; y++) begin
                    dy = y * 256 - cy;
                    if (dy < 0) dy = -dy;
                    for (longint x = x0; x <= x1; x++) begin
                        dx = x * 256 - cx;
                        if (dx < 0) dx = -dx;
                        e = longint'(dx * dx + dy * dy) * longint'(inv_sq);
                        wgt = '0;
                        if (e < (64'd16 << 32))
                            wgt = 32'(gauss_lut[(e * EXP_TABLE_DEPTH) >> 36]);
                        idx = int'(y * MAX_WIDTH + x);
                        s = longint'(density[idx]) + wgt;
                        density[idx] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
                        if (density[idx] > peak) peak = density[idx];
                    end
                end
            end
            OP_READ:
            begin
                v = 0;
                if (c.rx < w && c.ry < h && peak != 0) begin
                    v = longint'(density[c.ry * MAX_WIDTH + c.rx]) * 255 / peak;
                    if (v > 255) v = 255;
                end
                r = colormap(int'(v));
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sender side: one pending beat at a time, popped from the command queue.
    always @(posedge clk or negedge rst_n) begin
        heat_cmd_t c;
        if (!rst_n) begin
            in_valid <= 1'b0;
            opcode   <= OP_NONE;
            point_x  <= '0;
            point_y  <= '0;
            pixel_x  <= '0;
            pixel_y  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                c.op = op_t'(opcode);
                c.px = point_x;
                c.py = point_y;
                c.rx = pixel_x;
                c.ry = pixel_y;
                pixel_q.push_back(apply_item(c));
            end
            if (!in_valid || in_ready) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    c = cmd_q.pop_front();
                    opcode   <= c.op;
                    point_x  <= c.px;
                    point_y  <= c.py;
                    pixel_x  <= c.rx;
                    pixel_y  <= c.ry;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: random stalls plus one long hold-off that backs up the block.
    always @(posedge clk or negedge rst_n) begin
        heat_px_t x;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            beats_seen <= 0;
            hold_cnt   <= 0;
            held       <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                beats_seen <= beats_seen + 1;
                if (pixel_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fails++;
                end else begin
                    x = pixel_q.pop_front();
                    if (level !== x.level) begin
                        $error("level: expected %0d, got %0d", x.level, level);
                        fails++;
                    end
                    if (blue !== x.blue) begin
                        $error("blue: expected %0d, got %0d", x.blue, blue);
                        fails++;
                    end
                    if (green !== x.green) begin
                        $error("green: expected %0d, got %0d", x.green, green);
                        fails++;
                    end
                    if (red !== x.red) begin
                        $error("red: expected %0d, got %0d", x.red, red);
                        fails++;
                    end
                end
            end
            if (!held && beats_seen == 40) begin
                held      <= 1'b1;
                hold_cnt  <= 600;
                out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_reg(input logic [2:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[23:0];
        case (idx)
            CFG_WIDTH:  img_w  = val & 32'h1FF;
            CFG_HEIGHT: img_h  = val & 32'h1FF;
            CFG_SCALE:  scale  = val & 32'hFFFF;
            CFG_SIGMA:  sigma  = val & 32'hFFFF;
            CFG_INV:    inv_sq = val & 32'hFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic push(input op_t op, input int unsigned px, input int unsigned py,
                        input int unsigned rx, input int unsigned ry);
        heat_cmd_t c;
        c.op = op;
        c.px = px[15:0];
        c.py = py[15:0];
        c.rx = rx[7:0];
        c.ry = ry[7:0];
        cmd_q.push_back(c);
    endtask

    // Mostly points that land in the image; the rest span the full field.
    function automatic int unsigned pick_point(input int unsigned dim);
        int unsigned top;
        if ($urandom_range(99) < 15) return $urandom_range(65535);
        top = ((dim + 2) * 256) / scale;
        if (top > 65535) top = 65535;
        return $urandom_range(top);
    endfunction

    function automatic int unsigned pick_pixel(input int unsigned dim);
        if ($urandom_range(99) < 15 || dim == 0) return $urandom_range(255);
        return $urandom_range((dim > 256 ? 256 : dim) - 1);
    endfunction

    task automatic random_phase(input int unsigned n);
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 1)
                push(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else if (r < 6)
                push(OP_NONE, $urandom, $urandom, $urandom, $urandom);
            else if (r < 46)
                push(OP_ADD, pick_point(img_w), pick_point(img_h), $urandom, $urandom);
            else
                push(OP_READ, $urandom, $urandom, pick_pixel(img_w), pick_pixel(img_h));
        end
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned sc, input int unsigned sg,
                             input int unsigned iv);
        set_reg(CFG_WIDTH, w);
        set_reg(CFG_HEIGHT, h);
        set_reg(CFG_SCALE, sc);
        set_reg(CFG_SIGMA, sg);
        set_reg(CFG_INV, iv);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        longint unsigned yv, sum, term;
        cycles    = 0;
        fails     = 0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_idle = 35;
        recv_idle = 74;
        img_w  = 256;
        img_h  = 256;
        scale  = 256;
        sigma  = 256;
        inv_sq = 32768;
        foreach (density[i]) density[i] = '0;
        peak = '0;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            yv   = (longint'(k) << 29) / EXP_TABLE_DEPTH;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * yv) >> 30) / n;
                if (n % 2) sum = sum - term;
                else sum = sum + term;
            end
            repeat (5) sum = (sum * sum + (64'd1 << 29)) >> 30;
            gauss_lut[k] = 17'((sum + (64'd1 << 13)) >> 14);
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty image, corners, out-of-image point, unused opcode, clear.
        push(OP_READ, 0, 0, 0, 0);
        push(OP_ADD, 0, 0, 0, 0);
        push(OP_READ, 0, 0, 0, 0);
        push(OP_READ, 0, 0, 1, 1);
        push(OP_ADD, 255, 255, 0, 0);
        push(OP_READ, 0, 0, 255, 255);
        push(OP_READ, 0, 0, 254, 255);
        push(OP_ADD, 65535, 65535, 0, 0);
        push(OP_ADD, 100, 50, 0, 0);
        push(OP_ADD, 100, 50, 0, 0);
        push(OP_READ, 0, 0, 100, 50);
        push(OP_READ, 0, 0, 101, 50);
        push(OP_READ, 0, 0, 103, 52);
        push(OP_NONE, 65535, 65535, 255, 255);
        push(OP_READ, 0, 0, 100, 50);
        push(OP_CLEAR, 0, 0, 0, 0);
        push(OP_READ, 0, 0, 100, 50);
        push(OP_ADD, 3, 3, 0, 0);
        push(OP_READ, 0, 0, 3, 3);
        drain();

        configure(16, 12, 256, 512, 8192);
        push(OP_READ, 0, 0, 20, 5);
        push(OP_READ, 0, 0, 5, 200);
        random_phase(72);
        drain();

        configure(0, 511, 65535, 65535, 16777215);
        set_reg(CFG_UNUSED, 24'hFFFFFF);
        @(posedge clk);
        cfg_we <= 1'b0;
        random_phase(72);
        drain();

        send_idle = 74;
        recv_idle = 35;
        configure(256, 256, 1, 1, 1);
        random_phase(72);
        drain();

        configure(64, 40, 300, 0, 0);
        random_phase(72);
        drain();

        send_idle = 0;
        recv_idle = 0;
        configure(200, 256, 128, 700, 20000);
        random_phase(72);
        drain();

        configure(256, 256, 256, 256, 32768);
        random_phase(72);
        drain();

        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ghsc_pkg.sv
sv/ghsc_divider.sv
sv/gaussian_heatmap_splat_colormap.sv
sv/ghsc_checker.sv
tb/gaussian_heatmap_splat_colormap_tb.sv
